FILE: rtl/bitmap_page_allocator_defines.svh
// Assertion helpers for the page allocator.
// Both forms check on the rising clock edge and are disabled while reset is asserted.
`ifndef BITMAP_PAGE_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS

`define BPA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("bitmap page allocator: same-cycle check failed");

`define BPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("bitmap page allocator: next-cycle check failed");

`else

`define BPA_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BPA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/bpa_pkg.sv
package bpa_pkg;

	localparam int unsigned WORD_BITS = 32;
	localparam logic [WORD_BITS-1:0] FULL_WORD = 32'hFFFF_FFFF;

	// Request kinds.
	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_FREE = 3'b100
	} bpa_state_t;

	// Position of the lowest clear bit; the word must not be all ones.
	function automatic logic [4:0] lowest_clear(input logic [WORD_BITS-1:0] w);
		logic [4:0] res;
		res = 5'd0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (!w[b]) begin
				res = 5'(b);
			end
		end
		return res;
	endfunction

endpackage

FILE: rtl/bitmap_page_allocator.sv
// Bitmap first-fit page allocator. Each page has one used bit. The bits are packed into
// 32-bit words held in a memory with one write port and one registered read port.
// An allocate request scans the words upward from word 0, one word per cycle. It takes the
// lowest clear bit, sets it, and returns found = 1 with the page index (low 8 bits). When
// every page is taken it returns found = 0 and granted_page = 0. A free request clears the
// bit of page_index and returns nothing. An index at or above PAGE_COUNT is ignored.
// An allocate request holds in_ready low while it examines words, from 1 to
// (PAGE_COUNT+31)/32 of them. A free request holds in_ready low while it reads its word
// and writes it back. The one memory read port reads one word per cycle. A new request
// is taken while a result still waits in the output
// register. An allocate that finishes while that register is still full waits until the
// register is free. Reset clears a valid flag for each word; it does not sweep the memory.
// A word that has never been written reads as its reset value, which is zero, except that
// the tail bits at or above PAGE_COUNT in the last word are ones. So the block can take a
// request in the first cycle after reset.
module bitmap_page_allocator #(
	parameter int PAGE_COUNT = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       kind,
	input  logic [7:0] page_index,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       found,
	output logic [7:0] granted_page
);

`include "bitmap_page_allocator_defines.svh"

	localparam int WORD_COUNT = (PAGE_COUNT + 31) / 32;
	localparam int WAW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int TAIL = PAGE_COUNT % 32;
	localparam logic [31:0] TAIL_MASK = (TAIL == 0) ? 32'd0 : ~((32'd1 << TAIL) - 32'd1);
	localparam logic [WAW-1:0] LAST_WORD = WAW'(WORD_COUNT - 1);

	// Bitmap storage. vld_q marks words written since reset.
	logic [31:0]           mem [WORD_COUNT];
	logic [WORD_COUNT-1:0] vld_q;

	bpa_pkg::bpa_state_t state_q, state_d;
	logic [WAW-1:0] addr_q, addr_d;
	logic [WAW-1:0] rd_addr;
	logic [31:0]    rd_data_s1;
	logic           rd_vld_s1;

	// The free request keeps its bit position and range check while its word is read.
	logic [4:0] fbit_q;
	logic       frange_q;

	logic           mem_we;
	logic [WAW-1:0] mem_wa;
	logic [31:0]    mem_wd;

	logic [31:0]    word_eff;
	logic [4:0]     bit_sel;
	logic [31:0]    page_full;
	logic [31:0]    idx_word;
	logic [WAW-1:0] idx_waddr;
	logic           idx_in_range;
	logic           out_free;
	logic           load_out;
	logic           res_found;
	logic [7:0]     res_page;
	logic           accept;

	assign in_ready = (state_q == bpa_pkg::S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;

	assign idx_word     = 32'(page_index) >> 5;
	assign idx_waddr    = idx_word[WAW-1:0];
	assign idx_in_range = (32'(page_index) < 32'(PAGE_COUNT));

	// A word that has never been written reads as its reset value.
	always_comb begin
		if (rd_vld_s1) begin
			word_eff = rd_data_s1;
		end else if (addr_q == LAST_WORD) begin
			word_eff = TAIL_MASK;
		end else begin
			word_eff = 32'd0;
		end
	end

	assign bit_sel   = bpa_pkg::lowest_clear(word_eff);
	assign page_full = 32'({addr_q, bit_sel});

	always_comb begin
		state_d   = state_q;
		addr_d    = addr_q;
		rd_addr   = addr_q;
		mem_we    = 1'b0;
		mem_wa    = addr_q;
		mem_wd    = word_eff;
		load_out  = 1'b0;
		res_found = 1'b0;
		res_page  = 8'd0;
		unique case (state_q)
			bpa_pkg::S_IDLE: begin
				if (accept) begin
					if (kind == bpa_pkg::KIND_FREE) begin
						rd_addr = idx_waddr;
						addr_d  = idx_waddr;
						state_d = bpa_pkg::S_FREE;
					end else begin
						rd_addr = '0;
						addr_d  = '0;
						state_d = bpa_pkg::S_SCAN;
					end
				end
			end
			bpa_pkg::S_FREE: begin
				mem_we  = frange_q;
				mem_wd  = word_eff & ~(32'd1 << fbit_q);
				state_d = bpa_pkg::S_IDLE;
			end
			bpa_pkg::S_SCAN: begin
				if (word_eff != bpa_pkg::FULL_WORD) begin
					if (out_free) begin
						mem_we    = 1'b1;
						mem_wd    = word_eff | (32'd1 << bit_sel);
						load_out  = 1'b1;
						res_found = 1'b1;
						res_page  = page_full[7:0];
						state_d   = bpa_pkg::S_IDLE;
					end
				end else if (addr_q == LAST_WORD) begin
					if (out_free) begin
						load_out = 1'b1;
						state_d  = bpa_pkg::S_IDLE;
					end
				end else begin
					// Word is full: read the next one.
					addr_d  = addr_q + WAW'(1);
					rd_addr = addr_d;
				end
			end
			default: begin
				state_d = bpa_pkg::S_IDLE;
			end
		endcase
	end

	// Memory: one write and one registered read each cycle. A read issued in the same cycle
	// as a write to its word is never used, so no forwarding is needed.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= bpa_pkg::S_IDLE;
			addr_q    <= '0;
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q   <= state_d;
			addr_q    <= addr_d;
			rd_vld_s1 <= vld_q[rd_addr];
			if (mem_we) begin
				vld_q[mem_wa] <= 1'b1;
			end
			if (load_out) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fbit_q   <= page_index[4:0];
			frange_q <= idx_in_range;
		end
		if (load_out) begin
			found        <= res_found;
			granted_page <= res_page;
		end
	end

	`BPA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, !in_ready)
	`BPA_ASSERT_SAME(a_write_states, clk, arst_n, mem_we, state_q != bpa_pkg::S_IDLE)
	`BPA_ASSERT_NEXT(a_result_shown, clk, arst_n, load_out, out_valid && (found == $past(res_found)))
	`BPA_ASSERT_SAME(a_none_is_zero, clk, arst_n, out_valid && !found, granted_page == 8'd0)

endmodule

FILE: tb/sv/tb_top.sv
// Testbench for the bitmap first-fit page allocator.
// A local copy of the page bitmap predicts the grant of every allocate request. Each
// result from the block is checked against the oldest prediction that is still waiting.
module tb_top;

	localparam int PAGES = 256;
	localparam int WORDS = (PAGES + 31) / 32;
	// Time given for the block to go idle after the last result: long enough for an allocate
	// that scans every word or for a free, doubled for margin.
	localparam int SETTLE_CYCLES = 2 * (WORDS + 2);

	typedef struct packed {
		logic       found;
		logic [7:0] page;
	} page_grant_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic       kind;
	logic [7:0] page_index;
	logic       out_valid;
	logic       out_ready;
	logic       found;
	logic [7:0] granted_page;

	// Predicted bitmap, one used bit per page, packed 32 pages to a word.
	logic [bpa_pkg::WORD_BITS-1:0] used_words [WORDS];
	// Grants that the block still owes, oldest first.
	page_grant_t grant_queue [$];
	int unsigned mismatch_count;
	// While calm is set, neither side inserts idle cycles.
	bit calm;

	bitmap_page_allocator #(
		.PAGE_COUNT(PAGES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.page_index(page_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.found(found),
		.granted_page(granted_page)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Bitmap after reset: all real pages free, tail bits of a partial last word taken.
	task automatic clear_page_map();
		for (int w = 0; w < WORDS; w++) begin
			used_words[w] = '0;
		end
		if (PAGES % bpa_pkg::WORD_BITS != 0) begin
			used_words[WORDS-1] = ~((32'd1 << (PAGES % bpa_pkg::WORD_BITS)) - 32'd1);
		end
	endtask

	// Update the predicted bitmap for one accepted request. An allocate takes the lowest
	// free page scanning from word 0 and queues the grant; a free just clears the bit.
	task automatic track_request(input logic req_kind, input logic [7:0] idx);
		page_grant_t grant;
		bit hit;
		int page;
		grant = '0;
		hit = 1'b0;
		if (req_kind == bpa_pkg::KIND_FREE) begin
			// Indexes beyond the region are dropped so the tail bits stay set.
			if (int'(idx) < PAGES) begin
				used_words[idx / bpa_pkg::WORD_BITS][idx % bpa_pkg::WORD_BITS] = 1'b0;
			end
		end else begin
			for (int w = 0; w < WORDS && !hit; w++) begin
				if (used_words[w] != bpa_pkg::FULL_WORD) begin
					for (int b = 0; b < bpa_pkg::WORD_BITS && !hit; b++) begin
						if (!used_words[w][b]) begin
							used_words[w][b] = 1'b1;
							page = w * bpa_pkg::WORD_BITS + b;
							grant.found = 1'b1;
							grant.page = page[7:0];
							hit = 1'b1;
						end
					end
				end
			end
			// With no free page left the grant stays found = 0, page = 0.
			grant_queue.push_back(grant);
		end
	endtask

	// Present one request and hold it until the block takes it. The valid line is only
	// lowered when an idle cycle is inserted, so back-to-back requests never see valid
	// dropped and raised again in the same time step.
	task automatic send_request(input logic req_kind, input logic [7:0] idx);
		while (!calm && $urandom_range(0, 99) < 32) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= req_kind;
		page_index <= idx;
		do begin
			@(posedge clk);
		end while (!in_ready);
		track_request(req_kind, idx);
	endtask

	// Response side: check each accepted grant, then choose the next ready level.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (grant_queue.size() == 0) begin
				$display("%0t: unexpected result found=%0d granted_page=%0d",
					$time, found, granted_page);
				mismatch_count++;
			end else begin
				page_grant_t want;
				want = grant_queue.pop_front();
				if (found !== want.found) begin
					$display("%0t: found mismatch, expected %0d, actual %0d",
						$time, want.found, found);
					mismatch_count++;
				end
				if (granted_page !== want.page) begin
					$display("%0t: granted_page mismatch, expected %0d, actual %0d",
						$time, want.page, granted_page);
					mismatch_count++;
				end
			end
		end
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (calm) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= 32);
		end
	end

	// A handful of hand-picked requests: lowest-first grants, refill of a freed page,
	// a free of a page that is already free, and the lowest and highest page indexes.
	task automatic test_directed();
		send_request(bpa_pkg::KIND_ALLOC, 8'd0);
		send_request(bpa_pkg::KIND_ALLOC, 8'hFF);
		send_request(bpa_pkg::KIND_ALLOC, 8'h55);
		send_request(bpa_pkg::KIND_FREE, 8'd0);
		send_request(bpa_pkg::KIND_FREE, 8'd0);
		send_request(bpa_pkg::KIND_FREE, 8'd255);
		send_request(bpa_pkg::KIND_ALLOC, 8'hAA);
		send_request(bpa_pkg::KIND_FREE, 8'd1);
		send_request(bpa_pkg::KIND_ALLOC, 8'd0);
		send_request(bpa_pkg::KIND_ALLOC, 8'd0);
		send_request(bpa_pkg::KIND_FREE, 8'd128);
		send_request(bpa_pkg::KIND_FREE, 8'd2);
		send_request(bpa_pkg::KIND_ALLOC, 8'd7);
		send_request(bpa_pkg::KIND_ALLOC, 8'd0);
	endtask

	// Random traffic where allocate_pct percent of requests allocate. Page indexes are
	// random for both kinds, so every index bit toggles and allocates carry junk indexes.
	task automatic run_random_mix(input int count, input int allocate_pct);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) < allocate_pct) begin
				send_request(bpa_pkg::KIND_ALLOC, 8'($urandom));
			end else begin
				send_request(bpa_pkg::KIND_FREE, 8'($urandom));
			end
		end
	endtask

	// Mostly allocates: the region fills up, so the full-region result shows up often.
	task automatic test_fill_region();
		run_random_mix(450, 90);
	endtask

	// Mostly frees against a full or nearly full region, leaving scattered holes.
	task automatic test_drain_region();
		run_random_mix(350, 20);
	endtask

	// Balanced traffic with no idle cycles on either side.
	task automatic test_back_to_back();
		calm = 1'b1;
		run_random_mix(200, 50);
		calm = 1'b0;
	endtask

	// Balanced traffic with random idling, followed by another fill to full.
	task automatic test_mixed_traffic();
		run_random_mix(350, 55);
		run_random_mix(150, 85);
	endtask

	// Stop presenting requests, let every owed grant arrive, then give the block time
	// to finish a trailing free that has no result.
	task automatic wait_for_grants();
		in_valid <= 1'b0;
		while (grant_queue.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = bpa_pkg::KIND_ALLOC;
		page_index = 8'd0;
		calm = 1'b0;
		mismatch_count = 0;
		clear_page_map();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill_region();
		test_drain_region();
		test_back_to_back();
		test_mixed_traffic();
		wait_for_grants();

		if (grant_queue.size() != 0) begin
			$display("%0t: %0d grants never arrived", $time, grant_queue.size());
			mismatch_count++;
		end
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Hard stop in case the block hangs on a handshake.
	initial begin
		#1000000;
		$display("%0t: timeout", $time);
		$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/bpa_pkg.sv
rtl/bitmap_page_allocator.sv
tb/sv/tb_top.sv
